// ===== rtl/tpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// tpwm_pkg
// Types and constants shared by the throttle plausibility window monitor.
// ----------------------------------------------------------------------------
package tpwm_pkg;

  localparam int POS_W     = 14;
  localparam int TICK_W    = 16;
  localparam int BCUT_W    = 9;
  localparam int WTICKS_W  = 22;
  localparam int ENTRIES_W = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 22;

  // widths sized for the largest supported window depth (1024 entries)
  localparam int CNT_MAX_W = 11;
  localparam int ESUM_MAX_W = CNT_MAX_W + POS_W;

  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_ERROR_CUTOFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_ERROR_CUTOFF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_APPLIED_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_OPEN_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS          = 3'd4;

  typedef struct packed {
    logic [POS_W-1:0]  requested_position;
    logic [POS_W-1:0]  measured_position;
    logic [POS_W-1:0]  previous_request;
    logic [POS_W-1:0]  brake_position;
    logic [TICK_W-1:0] elapsed_ticks;
  } in_t;

  typedef struct packed {
    logic                 fault;
    logic [POS_W-1:0]     throttle_command;
    logic [ENTRIES_W-1:0] window_entries;
  } out_t;

  // one window store entry
  typedef struct packed {
    logic [POS_W-1:0]  err;
    logic              flag;
    logic [TICK_W-1:0] ticks;
  } ent_t;

  typedef struct packed {
    logic              start;
    logic [POS_W-1:0]  err;
    logic              flag;
    logic [TICK_W-1:0] ticks;
  } win_cmd_t;

  typedef struct packed {
    logic                  done;
    logic [ESUM_MAX_W-1:0] error_sum;
    logic [CNT_MAX_W-1:0]  brake_count;
    logic [CNT_MAX_W-1:0]  entry_count;
  } win_stat_t;

endpackage

// ===== rtl/tpwm_ram.sv =====
// ----------------------------------------------------------------------------
// tpwm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpwm_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tpwm_window.sv =====
// ----------------------------------------------------------------------------
// tpwm_window
// Circular window store with running sums: full-store drop, insert, and
// oldest-first eviction on total window time, one store access at a time.
// ----------------------------------------------------------------------------
module tpwm_window
  import tpwm_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  win_cmd_t            cmd,
  input  logic [WTICKS_W-1:0] window_ticks,
  output win_stat_t           stat
);

  localparam int IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int ESUM_W = CNT_W + POS_W;
  localparam int TIME_W = CNT_W + TICK_W;
  localparam int TCMP_W = (TIME_W > WTICKS_W) ? TIME_W : WTICKS_W;

  localparam logic [2:0] W_IDLE  = 3'd0;
  localparam logic [2:0] W_DROP  = 3'd1;
  localparam logic [2:0] W_WRITE = 3'd2;
  localparam logic [2:0] W_CHECK = 3'd3;
  localparam logic [2:0] W_EVICT = 3'd4;

  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  oldest_r, oldest_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ESUM_W-1:0] esum_r, esum_nxt;
  logic [CNT_W-1:0]  bcnt_r, bcnt_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  ent_t              new_r, new_nxt;

  ent_t              rd_ent;
  logic              win_done;
  logic              ram_we, ram_re;
  logic [CNT_W:0]    slot_sum;
  logic [IDX_W-1:0]  slot;
  logic [IDX_W-1:0]  oldest_inc;
  logic              over_time;

  tpwm_ram #(
    .WIDTH ($bits(ent_t)),
    .DEPTH (WINDOW_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (new_r),
    .re    (ram_re),
    .raddr (oldest_r),
    .rdata (rd_ent)
  );

  // write slot is oldest + count, wrapped once since the sum stays below 2x depth
  assign slot_sum   = (CNT_W + 1)'(oldest_r) + (CNT_W + 1)'(count_r);
  assign slot       = (slot_sum >= (CNT_W + 1)'(WINDOW_DEPTH)) ?
                      IDX_W'(slot_sum - (CNT_W + 1)'(WINDOW_DEPTH)) : IDX_W'(slot_sum);
  assign oldest_inc = (oldest_r == LAST_IDX) ? '0 : oldest_r + 1'b1;
  assign over_time  = (TCMP_W'(time_r) > TCMP_W'(window_ticks)) && (count_r > CNT_W'(1));

  always_comb begin
    state_nxt  = state_r;
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    esum_nxt   = esum_r;
    bcnt_nxt   = bcnt_r;
    time_nxt   = time_r;
    new_nxt    = new_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    win_done   = 1'b0;
    unique case (state_r)
      W_IDLE: begin
        if (cmd.start) begin
          new_nxt.err   = cmd.err;
          new_nxt.flag  = cmd.flag;
          new_nxt.ticks = cmd.ticks;
          if (count_r == DEPTH_C) begin
            ram_re    = 1'b1;
            state_nxt = W_DROP;
          end else begin
            state_nxt = W_WRITE;
          end
        end
      end
      W_DROP, W_EVICT: begin
        esum_nxt   = esum_r - ESUM_W'(rd_ent.err);
        bcnt_nxt   = bcnt_r - CNT_W'(rd_ent.flag);
        time_nxt   = time_r - TIME_W'(rd_ent.ticks);
        count_nxt  = count_r - 1'b1;
        oldest_nxt = oldest_inc;
        state_nxt  = (state_r == W_DROP) ? W_WRITE : W_CHECK;
      end
      W_WRITE: begin
        ram_we    = 1'b1;
        esum_nxt  = esum_r + ESUM_W'(new_r.err);
        bcnt_nxt  = bcnt_r + CNT_W'(new_r.flag);
        time_nxt  = time_r + TIME_W'(new_r.ticks);
        count_nxt = count_r + 1'b1;
        state_nxt = W_CHECK;
      end
      W_CHECK: begin
        if (over_time) begin
          ram_re    = 1'b1;
          state_nxt = W_EVICT;
        end else begin
          win_done  = 1'b1;
          state_nxt = W_IDLE;
        end
      end
      default: begin
        state_nxt = W_IDLE;
      end
    endcase
  end

  assign stat.done        = win_done;
  assign stat.error_sum   = ESUM_MAX_W'(esum_r);
  assign stat.brake_count = CNT_MAX_W'(bcnt_r);
  assign stat.entry_count = CNT_MAX_W'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= W_IDLE;
      oldest_r <= '0;
      count_r  <= '0;
      esum_r   <= '0;
      bcnt_r   <= '0;
      time_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      esum_r   <= esum_nxt;
      bcnt_r   <= bcnt_nxt;
      time_r   <= time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_r <= new_nxt;
  end

endmodule

// ===== rtl/throttle_plausibility_window_monitor.sv =====
// ----------------------------------------------------------------------------
// throttle_plausibility_window_monitor
// Tracks throttle error and brake conflicts over a time window and faults
// when the window mean error or the brake-conflict fraction passes a cutoff.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------
//   in_      | input     | in_valid/in_ready  | in_t (five sample fields)
//   out_     | output    | out_valid/out_ready| out_t (fault, command, count)
//   cfg_     | input     | cfg_we             | cfg_index, cfg_wdata
//
// A sample passes from its accept edge through the window states (a drop
// when the store is full, the write, the check and one eviction per
// evicted entry) and the registered products to the output register;
// every store read is registered on the single window RAM.
// The next sample is accepted once its result sits in the output register.
// Reset is synchronous; the store contents need no clearing.
// A stalled output holds the finished result and the next sample's work.
// ----------------------------------------------------------------------------
module throttle_plausibility_window_monitor
  import tpwm_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata
);

  localparam int P1_W = POS_W + CNT_MAX_W;
  localparam int P2_W = BCUT_W + CNT_MAX_W;

  logic [POS_W-1:0]    err_cut_r;
  logic [BCUT_W-1:0]   brake_cut_r;
  logic [POS_W-1:0]    brake_lvl_r;
  logic [POS_W-1:0]    open_lvl_r;
  logic [WTICKS_W-1:0] wticks_r;

  logic                busy_r;
  logic                prod_v_r;
  logic [POS_W-1:0]    req_r;
  logic [ESUM_MAX_W-1:0] esum_r;
  logic [P1_W-1:0]     p1_r;
  logic [P2_W-1:0]     bc_scaled_r;
  logic [P2_W-1:0]     p2_r;
  logic [CNT_MAX_W-1:0] cnt_r;
  logic                out_valid_r;
  out_t                out_r;

  win_cmd_t            cmd;
  win_stat_t           stat;
  logic                in_xfer;
  logic                load_out;
  logic                fault;

  assign in_ready = !busy_r;
  assign in_xfer  = in_valid && in_ready;

  assign cmd.start = in_xfer;
  assign cmd.err   = (in_data.measured_position > in_data.previous_request) ?
                     in_data.measured_position - in_data.previous_request :
                     in_data.previous_request - in_data.measured_position;
  assign cmd.flag  = (in_data.brake_position > brake_lvl_r) &&
                     (in_data.measured_position > open_lvl_r);
  assign cmd.ticks = in_data.elapsed_ticks;

  tpwm_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .window_ticks (wticks_r),
    .stat         (stat)
  );

  // cross-multiplied mean tests, compared combinationally on the registered products
  assign fault    = (ESUM_MAX_W'(P1_W'(esum_r)) > ESUM_MAX_W'(p1_r)) || (bc_scaled_r > p2_r);
  assign load_out = prod_v_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_cut_r   <= POS_W'(1000);
      brake_cut_r <= BCUT_W'(128);
      brake_lvl_r <= POS_W'(500);
      open_lvl_r  <= POS_W'(1000);
      wticks_r    <= WTICKS_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THROTTLE_ERROR_CUTOFF: err_cut_r   <= cfg_wdata[POS_W-1:0];
        REG_BRAKE_ERROR_CUTOFF:    brake_cut_r <= cfg_wdata[BCUT_W-1:0];
        REG_BRAKE_APPLIED_LEVEL:   brake_lvl_r <= cfg_wdata[POS_W-1:0];
        REG_THROTTLE_OPEN_LEVEL:   open_lvl_r  <= cfg_wdata[POS_W-1:0];
        REG_WINDOW_TICKS:          wticks_r    <= cfg_wdata[WTICKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy_r <= 1'b1;
      end else if (load_out) begin
        busy_r <= 1'b0;
      end
      if (stat.done) begin
        prod_v_r <= 1'b1;
      end else if (load_out) begin
        prod_v_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_data.requested_position;
    end
    if (stat.done) begin
      esum_r      <= stat.error_sum;
      cnt_r       <= stat.entry_count;
      p1_r        <= P1_W'(err_cut_r) * P1_W'(stat.entry_count);
      p2_r        <= P2_W'(brake_cut_r) * P2_W'(stat.entry_count);
      bc_scaled_r <= P2_W'({stat.brake_count, 8'd0});
    end
    if (load_out) begin
      out_r.fault            <= fault;
      out_r.throttle_command <= fault ? '0 : req_r;
      out_r.window_entries   <= cnt_r[ENTRIES_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
